[hdl/assert_macros.svh]
// Assertion macros shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hdl/cst_pkg.sv]
// Shared types, codes and constants of the character stream tokenizer.
package cst_pkg;

  localparam logic [2:0] KIND_END    = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_IDENT  = 3'd2;
  localparam logic [2:0] KIND_DEF    = 3'd3;
  localparam logic [2:0] KIND_SINGLE = 3'd4;
  localparam logic [2:0] KIND_ICHAR  = 3'd5;

  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [30:0] NUM_MAX   = 31'h7FFF_FFFF;
  localparam logic [7:0]  LEN_MAX   = 8'd255;
  localparam logic [7:0]  KW_LEN    = 8'd3;

  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);

  // Classified input item.
  typedef struct packed {
    logic       eoi;
    logic [7:0] ch;
    logic       letter;
    logic       digit;
    logic       space;
    logic       hash;
    logic       eol;
    logic [3:0] dig;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic [30:0] num;
    logic [7:0]  len;
    logic        last;
  } res_t;

  // Results written by the scanner in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } resq_wr_t;

  // Keyword text "def", one character per position.
  function automatic logic [7:0] kw_char(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h64;
      2'd1:    c = 8'h65;
      2'd2:    c = 8'h66;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                  input logic [30:0] num, input logic [7:0] len);
    res_t r;
    r.kind = kind;
    r.ch   = ch;
    r.num  = num;
    r.len  = len;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[hdl/cst_front.sv]
// Front end: accepts input bytes, classifies them and queues them for the scanner.
`include "assert_macros.svh"

module cst_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     char_code,
  input  logic           end_of_input,
  output logic           full,
  output logic           head_valid,
  output cst_pkg::item_t head,
  input  logic           take
);

  cst_pkg::item_t q [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;
  cst_pkg::item_t cls;

  always_comb begin
    cls.eoi    = end_of_input;
    cls.ch     = char_code;
    cls.letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                 ((char_code >= 8'h41) && (char_code <= 8'h5A));
    cls.digit  = (char_code >= cst_pkg::CHAR_ZERO) && (char_code <= cst_pkg::CHAR_NINE);
    cls.space  = (char_code == cst_pkg::CHAR_SPACE) ||
                 ((char_code >= cst_pkg::CHAR_TAB) && (char_code <= cst_pkg::CHAR_CR));
    cls.hash   = (char_code == cst_pkg::CHAR_HASH);
    cls.eol    = (char_code == cst_pkg::CHAR_LF) || (char_code == cst_pkg::CHAR_CR);
    cls.dig    = 4'(char_code - cst_pkg::CHAR_ZERO);
  end

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rptr];
  assign do_push    = push && !full;
  assign do_pop     = take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `ASSERT_NEVER(a_take_empty, clk, rst, take && !head_valid, "scanner took from empty queue")

endmodule

[hdl/cst_back.sv]
// Back end: scan state machine that turns classified items into result items.
`include "assert_macros.svh"

module cst_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  cst_pkg::item_t    head,
  output logic              take,
  input  logic              room,
  output cst_pkg::resq_wr_t wr
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT
  } mode_t;

  mode_t       mode;
  mode_t       mode_next;
  logic [30:0] acc;
  logic [30:0] acc_next;
  logic [7:0]  cnt;
  logic [7:0]  cnt_next;
  logic        kw;
  logic        kw_next;
  logic [7:0]  cnt_inc;
  logic [34:0] prod;
  logic [30:0] acc_mac;
  cst_pkg::res_t r0;
  cst_pkg::res_t r1;
  cst_pkg::res_t extra;
  cst_pkg::res_t ident_res;
  logic        extra_ok;
  logic        idle_run;
  logic [1:0]  n;

  assign take    = head_valid && room;
  assign cnt_inc = (cnt == cst_pkg::LEN_MAX) ? cnt : cnt + 8'd1;

  // value * 10 + digit, saturated
  assign prod    = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, head.dig};
  assign acc_mac = (|prod[34:31]) ? cst_pkg::NUM_MAX : prod[30:0];

  assign ident_res = cst_pkg::mk_res(
      (kw && (cnt == cst_pkg::KW_LEN)) ? cst_pkg::KIND_DEF : cst_pkg::KIND_IDENT,
      8'd0, 31'd0, cnt);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    kw_next   = kw;
    r0        = '0;
    r1        = '0;
    extra     = '0;
    extra_ok  = 1'b0;
    idle_run  = 1'b0;
    n         = 2'd0;
    if (head.eoi) begin
      if (mode == MODE_IDENT) begin
        r0 = ident_res;
        n  = 2'd1;
      end else if (mode == MODE_NUMBER) begin
        r0 = cst_pkg::mk_res(cst_pkg::KIND_NUMBER, 8'd0, acc, 8'd0);
        n  = 2'd1;
      end
      extra     = cst_pkg::mk_res(cst_pkg::KIND_END, 8'd0, 31'd0, 8'd0);
      extra_ok  = 1'b1;
      mode_next = MODE_IDLE;
      acc_next  = '0;
      cnt_next  = '0;
      kw_next   = 1'b0;
    end else begin
      unique case (mode)
        MODE_IDENT: begin
          if (head.letter || head.digit) begin
            kw_next  = kw && (cnt < cst_pkg::KW_LEN) && (head.ch == cst_pkg::kw_char(cnt[1:0]));
            cnt_next = cnt_inc;
            r0       = cst_pkg::mk_res(cst_pkg::KIND_ICHAR, head.ch, 31'd0, 8'd0);
            n        = 2'd1;
          end else begin
            r0        = ident_res;
            n         = 2'd1;
            cnt_next  = '0;
            kw_next   = 1'b0;
            mode_next = MODE_IDLE;
            idle_run  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (head.digit) begin
            acc_next = acc_mac;
          end else begin
            r0        = cst_pkg::mk_res(cst_pkg::KIND_NUMBER, 8'd0, acc, 8'd0);
            n         = 2'd1;
            acc_next  = '0;
            mode_next = MODE_IDLE;
            idle_run  = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (head.eol) begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
          idle_run = 1'b1;
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end

    // The ending byte is handled as in idle mode.
    if (idle_run) begin
      priority if (head.space) begin
        mode_next = mode_next;
      end else if (head.letter) begin
        mode_next = MODE_IDENT;
        cnt_next  = 8'd1;
        kw_next   = (head.ch == cst_pkg::kw_char(2'd0));
        extra     = cst_pkg::mk_res(cst_pkg::KIND_ICHAR, head.ch, 31'd0, 8'd0);
        extra_ok  = 1'b1;
      end else if (head.digit) begin
        mode_next = MODE_NUMBER;
        acc_next  = {27'd0, head.dig};
      end else if (head.hash) begin
        mode_next = MODE_COMMENT;
      end else begin
        extra    = cst_pkg::mk_res(cst_pkg::KIND_SINGLE, head.ch, 31'd0, 8'd0);
        extra_ok = 1'b1;
      end
    end

    if (extra_ok) begin
      if (n == 2'd0) begin
        r0 = extra;
        n  = 2'd1;
      end else begin
        r1 = extra;
        n  = 2'd2;
      end
    end

    // Mark the final result of the item.
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign wr.count = take ? n : 2'd0;
  assign wr.r0    = r0;
  assign wr.r1    = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc  <= '0;
      cnt  <= '0;
      kw   <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      acc  <= acc_next;
      cnt  <= cnt_next;
      kw   <= kw_next;
    end
  end

  `ASSERT_CLK(a_eoi_clears, clk, rst, take && head.eoi |=> (mode == MODE_IDLE) && (acc == '0) && (cnt == '0), "end mark left scan state")
  `ASSERT_CLK(a_eoi_ends, clk, rst, take && head.eoi |-> (wr.count != 2'd0) && ((wr.count == 2'd1) ? (wr.r0.kind == cst_pkg::KIND_END) : (wr.r1.kind == cst_pkg::KIND_END)), "end mark gave no end token")

endmodule

[hdl/cst_resq.sv]
// Result queue: takes up to two results a cycle, hands out one a cycle.
`include "assert_macros.svh"

module cst_resq (
  input  logic              clk,
  input  logic              rst,
  input  cst_pkg::resq_wr_t wr,
  output logic              room,
  output logic              empty,
  input  logic              pop,
  output cst_pkg::res_t     head
);

  localparam int unsigned AW = cst_pkg::RESQ_AW;

  cst_pkg::res_t mem [cst_pkg::RESQ_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic          do_pop;

  assign empty  = (count == '0);
  assign room   = (count <= (AW+1)'(cst_pkg::RESQ_DEPTH - 2));
  assign head   = mem[rptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) begin
      mem[wptr] <= wr.r0;
    end
    if (wr.count == 2'd2) begin
      mem[wptr + AW'(1)] <= wr.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr.count);
      if (do_pop) begin
        rptr <= rptr + AW'(1);
      end
      count <= count + (AW+1)'(wr.count) - (AW+1)'(do_pop);
    end
  end

  `ASSERT_CLK(a_no_overflow, clk, rst, (wr.count != 2'd0) |-> ((AW+2)'(count) + (AW+2)'(wr.count) <= (AW+2)'(cst_pkg::RESQ_DEPTH) + (AW+2)'(do_pop)), "result queue overflow")

endmodule

[hdl/char_stream_tokenizer.sv]
// Top level of the character stream tokenizer.
//
//  channel   direction  handshake       payload
//  input     in         push / full     char_code, end_of_input
//  result    out        pop / empty     token_kind, char_value, number_value,
//                                       ident_length, last_of_item
//
// One item a cycle is accepted unless full; the classifier queue holds two items.
// Each item gives zero to two results; the result queue delivers one a cycle,
// so one item a cycle is sustained while results drain as fast, at most one per item.
// An item's first result passes the classifier queue and result queue to the ports.
// rst is synchronous and clears the queues and the scan state; no clearing pass.
// A stalled consumer backs up the result queue, then the scanner, then full.
module char_stream_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind,
  output logic [7:0]  char_value,
  output logic [30:0] number_value,
  output logic [7:0]  ident_length,
  output logic        last_of_item
);

  logic              head_valid;
  cst_pkg::item_t    head;
  logic              take;
  logic              room;
  cst_pkg::resq_wr_t wr;
  cst_pkg::res_t     res;

  cst_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .full         (full),
    .head_valid   (head_valid),
    .head         (head),
    .take         (take)
  );

  cst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .room       (room),
    .wr         (wr)
  );

  cst_resq u_resq (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .room  (room),
    .empty (empty),
    .pop   (pop),
    .head  (res)
  );

  assign token_kind   = res.kind;
  assign char_value   = res.ch;
  assign number_value = res.num;
  assign ident_length = res.len;
  assign last_of_item = res.last;

endmodule

[tb/char_stream_tokenizer_test.sv]
// Self-checking testbench for the character stream tokenizer.
`timescale 1ns / 100ps

module char_stream_tokenizer_test;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_COMMENT} scan_mode_e;

  // One row of the directed table; n_typed > 0 means the tokens are written out.
  typedef struct packed {
    logic [7:0]    c;
    logic          eoi;
    logic [1:0]    n_typed;
    cst_pkg::res_t t0;
    cst_pkg::res_t t1;
  } dir_row_t;

  localparam logic [23:0] KW_WORD     = "def";
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          STALL_LEN   = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_input = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  token_kind;
  logic [7:0]  char_value;
  logic [30:0] number_value;
  logic [7:0]  ident_length;
  logic        last_of_item;

  // Lexer state mirrored by the predictor.
  scan_mode_e  scan_mode = SCAN_IDLE;
  logic [30:0] num_acc = '0;
  logic [7:0]  id_len = '0;
  logic        kw_ok = 1'b0;

  cst_pkg::res_t item_tokens[$];
  cst_pkg::res_t typed_tokens[$];
  cst_pkg::res_t expected_tokens[$];
  cst_pkg::res_t seen_token;
  dir_row_t      dir_rows[$];

  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;

  string kw_like[6] = '{"def", "de", "deff", "dEf", "def9", "xdef"};
  string punct = "+-*/()<>;,=!";

  char_stream_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .char_code(char_code),
    .end_of_input(end_of_input),
    .empty(empty),
    .pop(pop),
    .token_kind(token_kind),
    .char_value(char_value),
    .number_value(number_value),
    .ident_length(ident_length),
    .last_of_item(last_of_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic cst_pkg::res_t make_token(input logic [2:0] kind, input logic [7:0] ch,
                                               input logic [30:0] num, input logic [7:0] len,
                                               input logic last);
    cst_pkg::res_t t;
    t.kind = kind;
    t.ch   = ch;
    t.num  = num;
    t.len  = len;
    t.last = last;
    return t;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= cst_pkg::CHAR_ZERO && c <= cst_pkg::CHAR_NINE;
  endfunction

  task automatic ident_add(input logic [7:0] c);
    int pos;
    pos = id_len;
    kw_ok = (kw_ok && pos < 3) ? (c == KW_WORD[8*(2-pos) +: 8]) : 1'b0;
    if (id_len < cst_pkg::LEN_MAX) id_len = id_len + 8'd1;
  endtask

  task automatic flush_ident();
    logic [2:0] kind;
    kind = (kw_ok && id_len == cst_pkg::KW_LEN) ? cst_pkg::KIND_DEF : cst_pkg::KIND_IDENT;
    item_tokens.push_back(make_token(kind, 8'h00, '0, id_len, 1'b0));
    id_len = '0;
    kw_ok = 1'b0;
  endtask

  task automatic idle_byte(input logic [7:0] c);
    if (c == cst_pkg::CHAR_SPACE || (c >= cst_pkg::CHAR_TAB && c <= cst_pkg::CHAR_CR)) begin
      return;
    end
    if (is_letter(c)) begin
      scan_mode = SCAN_IDENT;
      id_len = '0;
      kw_ok = 1'b1;
      ident_add(c);
      item_tokens.push_back(make_token(cst_pkg::KIND_ICHAR, c, '0, '0, 1'b0));
    end else if (is_digit(c)) begin
      scan_mode = SCAN_NUMBER;
      num_acc = 31'(c - cst_pkg::CHAR_ZERO);
    end else if (c == cst_pkg::CHAR_HASH) begin
      scan_mode = SCAN_COMMENT;
    end else begin
      item_tokens.push_back(make_token(cst_pkg::KIND_SINGLE, c, '0, '0, 1'b0));
    end
  endtask

  // Work out the tokens that one accepted item gives, and advance the state.
  task automatic lex_item(input logic [7:0] c, input logic eoi);
    logic [63:0]   v;
    cst_pkg::res_t t;
    item_tokens.delete();
    if (eoi) begin
      if (scan_mode == SCAN_IDENT) begin
        flush_ident();
      end else if (scan_mode == SCAN_NUMBER) begin
        item_tokens.push_back(make_token(cst_pkg::KIND_NUMBER, 8'h00, num_acc, '0, 1'b0));
      end
      item_tokens.push_back(make_token(cst_pkg::KIND_END, 8'h00, '0, '0, 1'b0));
      scan_mode = SCAN_IDLE;
      num_acc = '0;
      id_len = '0;
      kw_ok = 1'b0;
    end else begin
      case (scan_mode)
        SCAN_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            ident_add(c);
            item_tokens.push_back(make_token(cst_pkg::KIND_ICHAR, c, '0, '0, 1'b0));
          end else begin
            flush_ident();
            scan_mode = SCAN_IDLE;
            idle_byte(c);
          end
        end
        SCAN_NUMBER: begin
          if (is_digit(c)) begin
            v = num_acc * 64'd10 + (c - cst_pkg::CHAR_ZERO);
            num_acc = (v > cst_pkg::NUM_MAX) ? cst_pkg::NUM_MAX : v[30:0];
          end else begin
            item_tokens.push_back(make_token(cst_pkg::KIND_NUMBER, 8'h00, num_acc, '0, 1'b0));
            num_acc = '0;
            scan_mode = SCAN_IDLE;
            idle_byte(c);
          end
        end
        SCAN_COMMENT: begin
          if (c == cst_pkg::CHAR_LF || c == cst_pkg::CHAR_CR) scan_mode = SCAN_IDLE;
        end
        default: begin
          idle_byte(c);
        end
      endcase
    end
    if (item_tokens.size() > 0) begin
      t = item_tokens.pop_back();
      t.last = 1'b1;
      item_tokens.push_back(t);
    end
  endtask

  task automatic report_mismatch(input string what, input cst_pkg::res_t got,
                                 input cst_pkg::res_t exp);
    string got_s;
    string exp_s;
    got_s = $sformatf("got kind %0d ch %02h num %0d len %0d last %0d",
                      got.kind, got.ch, got.num, got.len, got.last);
    exp_s = $sformatf("expected kind %0d ch %02h num %0d len %0d last %0d",
                      exp.kind, exp.ch, exp.num, exp.len, exp.last);
    $display("%0t %s: %s, %s", $time, what, got_s, exp_s);
    error_count++;
  endtask

  // Offer one item until accepted, then queue what it should give.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    char_code <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    lex_item(c, eoi);
    if (typed_tokens.size() > 0) begin
      foreach (typed_tokens[i]) expected_tokens.push_back(typed_tokens[i]);
      typed_tokens.delete();
    end else begin
      foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
    end
  endtask

  task automatic drain_pause();
    push <= 1'b0;
    @(posedge clk);
    wait (expected_tokens.size() == 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? 8'(cst_pkg::CHAR_ZERO + $urandom_range(0, 9))
                                       : rand_letter();
  endfunction

  // Emit one random token: mostly well-formed tokens, some noise.
  task automatic rand_token();
    int    pick;
    int    n;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      if ($urandom_range(0, 3) == 0) begin
        s = kw_like[$urandom_range(0, 5)];
        for (int j = 0; j < s.len(); j++) send_item(s[j], 1'b0);
      end else begin
        n = $urandom_range(1, 8);
        send_item(rand_letter(), 1'b0);
        for (int j = 1; j < n; j++) send_item(rand_alnum(), 1'b0);
      end
    end else if (pick < 50) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 6);
      for (int j = 0; j < n; j++) begin
        send_item(8'(cst_pkg::CHAR_ZERO + $urandom_range(0, 9)), 1'b0);
      end
    end else if (pick < 60) begin
      send_item(cst_pkg::CHAR_HASH, 1'b0);
      n = $urandom_range(0, 6);
      for (int j = 0; j < n; j++) send_item(8'($urandom_range(0, 255)), 1'b0);
      n = $urandom_range(0, 9);
      if (n < 4) send_item(cst_pkg::CHAR_LF, 1'b0);
      else if (n < 8) send_item(cst_pkg::CHAR_CR, 1'b0);
      else send_item(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 75) begin
      n = $urandom_range(0, 5);
      send_item((n == 5) ? cst_pkg::CHAR_SPACE : 8'(cst_pkg::CHAR_TAB + n), 1'b0);
    end else if (pick < 90) begin
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(128, 255)), 1'b0);
      else send_item(punct[$urandom_range(0, punct.len() - 1)], 1'b0);
    end else if (pick < 96) begin
      send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Result side: compare each accepted token with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && !empty && pop) begin
      seen_token = make_token(token_kind, char_value, number_value, ident_length,
                              last_of_item);
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token", seen_token, '0);
      end else if (seen_token !== expected_tokens[0]) begin
        report_mismatch("wrong token", seen_token, expected_tokens.pop_front());
      end else begin
        void'(expected_tokens.pop_front());
      end
    end
  end

  // Receiver: random pops, or a long hold when asked.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        pop <= 1'b0;
        repeat (STALL_LEN) @(posedge clk);
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    dir_rows.push_back('{8'h00, 1'b1, 2'd1,
                         make_token(cst_pkg::KIND_END, 8'h00, '0, '0, 1'b1), '0});
    dir_rows.push_back('{"d", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"e", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"f", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{cst_pkg::CHAR_TAB, 1'b0, 2'd1,
                         make_token(cst_pkg::KIND_DEF, 8'h00, '0, cst_pkg::KW_LEN, 1'b1),
                         '0});
    // Run past 2^31-1 to hit saturation.
    dir_rows.push_back('{"2", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"1", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"4", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"7", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"4", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"8", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"3", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"6", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"4", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"8", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'hFF, 1'b0, 2'd2,
                         make_token(cst_pkg::KIND_NUMBER, 8'h00, cst_pkg::NUM_MAX, '0, 1'b0),
                         make_token(cst_pkg::KIND_SINGLE, 8'hFF, '0, '0, 1'b1)});
    // Number followed directly by a letter.
    dir_rows.push_back('{"7", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{"Z", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{cst_pkg::CHAR_HASH, 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{cst_pkg::CHAR_CR, 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'h00, 1'b0, 2'd1,
                         make_token(cst_pkg::KIND_SINGLE, 8'h00, '0, '0, 1'b1), '0});
    // Comment dropped at end of input.
    dir_rows.push_back('{cst_pkg::CHAR_HASH, 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'hFF, 1'b1, 2'd1,
                         make_token(cst_pkg::KIND_END, 8'h00, '0, '0, 1'b1), '0});
    dir_rows.push_back('{"5", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'hA5, 1'b1, 2'd0, '0, '0});
    dir_rows.push_back('{"a", 1'b0, 2'd0, '0, '0});
    dir_rows.push_back('{8'h5A, 1'b1, 2'd0, '0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 78;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].n_typed > 0) typed_tokens.push_back(dir_rows[i].t0);
      if (dir_rows[i].n_typed > 1) typed_tokens.push_back(dir_rows[i].t1);
      send_item(dir_rows[i].c, dir_rows[i].eoi);
    end

    // Long identifier saturates its length.
    send_item("q", 1'b0);
    for (int j = 0; j < 259; j++) send_item(rand_alnum(), 1'b0);
    send_item(cst_pkg::CHAR_SPACE, 1'b0);
    while (items_sent < 330) rand_token();
    drain_pause();

    send_idle_pct = 78;
    recv_idle_pct = 14;
    while (items_sent < 640) rand_token();
    drain_pause();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    while (items_sent < 950) rand_token();

    push <= 1'b0;
    @(posedge clk);
    wait (expected_tokens.size() == 0);
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
